FILE: hdl/sh13_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SipHash-1-3 shared definitions
// State type, key and initialisation constants, and helper functions used by
// the hasher top level and its half-round unit.
// ----------------------------------------------------------------------------
package sh13_pkg;

    localparam logic [63:0] SIP_C0 = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] SIP_C1 = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] SIP_C3 = 64'h7465_6462_7974_6573;

    localparam logic [63:0] KEY_LOW_RESET  = 64'h0706_0504_0302_0100;
    localparam logic [63:0] KEY_HIGH_RESET = 64'h0f0e_0d0c_0b0a_0908;

    localparam logic [63:0] FIN_XOR = 64'h0000_0000_0000_00ff;

    localparam logic [3:0] FULL_BYTES = 4'd8;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    localparam logic PHASE_A = 1'b0;
    localparam logic PHASE_B = 1'b1;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_vstate;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_vstate key_load(input logic [63:0] key_lo,
                                         input logic [63:0] key_hi);
        t_vstate s;
        s.v0 = key_lo ^ SIP_C0;
        s.v1 = key_hi ^ SIP_C1;
        s.v2 = key_lo ^ SIP_C2;
        s.v3 = key_hi ^ SIP_C3;
        key_load = s;
    endfunction

    // Final block: valid bytes of a short word, length in the top byte.
    function automatic logic [63:0] block_fmt(input logic [63:0] word,
                                              input logic [3:0]  cnt,
                                              input logic [7:0]  len);
        logic [63:0] b;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            if (cnt != FULL_BYTES && 4'(i) < cnt) begin
                b[8*i +: 8] = word[8*i +: 8];
            end
        end
        b[63:56] = len;
        block_fmt = b;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/siphash_1_3_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SipHash-1-3 hasher
// Keyed 64-bit hash of a word stream; SipRounds run as two half rounds on one
// shared unit under a small sequencer.
// ----------------------------------------------------------------------------
// Each word is accepted, then compressed by two half rounds before the next.
// A full last word adds a length block; the result is registered at the end of
// finalisation, held until taken while the next message may start.
// Rate is set by the single half-round unit (two 64-bit adds per cycle).
// Synchronous active-low reset: key 00..0f, state loaded from key, no result.
module siphash_1_3_hasher
    import sh13_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_hash_value,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_FIN
    } t_state;

    localparam logic [2:0] FIN_LAST = 3'd5;

    t_state      r_state, n_state;
    t_vstate     r_v, n_v;
    t_vstate     hr_v;
    logic [63:0] r_key_lo, n_key_lo;
    logic [63:0] r_key_hi, n_key_hi;
    logic [7:0]  r_len, n_len;
    logic [63:0] r_m, n_m;
    logic [63:0] r_blk, n_blk;
    logic        r_pend, n_pend;
    logic        r_fin, n_fin;
    logic [2:0]  r_half, n_half;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_hash, n_hash;

    logic        in_acc;
    logic [3:0]  cnt_sat;
    logic [63:0] blk;

    sh13_half_round u_half_round (
        .i_phase (r_half[0]),
        .i_v     (r_v),
        .o_v     (hr_v)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;
    assign in_acc       = i_in_valid && o_in_ready;
    assign cnt_sat      = (i_byte_count > FULL_BYTES) ? FULL_BYTES : i_byte_count;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_key_lo    = r_key_lo;
        n_key_hi    = r_key_hi;
        n_len       = r_len;
        n_m         = r_m;
        n_blk       = r_blk;
        n_pend      = r_pend;
        n_fin       = r_fin;
        n_half      = r_half;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && !i_out_ready;
        blk         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_COMP;
                    n_half  = '0;
                    if (!i_last) begin
                        n_len    = r_len + 8'(FULL_BYTES);
                        n_m      = i_data_word;
                        n_v.v3   = r_v.v3 ^ i_data_word;
                        n_pend   = 1'b0;
                        n_fin    = 1'b0;
                    end else begin
                        n_len = r_len + {4'd0, cnt_sat};
                        blk   = block_fmt(i_data_word, cnt_sat, n_len);
                        n_fin = 1'b1;
                        if (cnt_sat == FULL_BYTES) begin
                            n_m    = i_data_word;
                            n_blk  = blk;
                            n_pend = 1'b1;
                            n_v.v3 = r_v.v3 ^ i_data_word;
                        end else begin
                            n_m    = blk;
                            n_pend = 1'b0;
                            n_v.v3 = r_v.v3 ^ blk;
                        end
                    end
                end
            end
            S_COMP: begin
                n_v = hr_v;
                if (r_half[0] == PHASE_A) begin
                    n_half = 3'd1;
                end else begin
                    n_half = '0;
                    n_v.v0 = hr_v.v0 ^ r_m;
                    priority if (r_pend) begin
                        // length block follows a full last word
                        n_pend = 1'b0;
                        n_m    = r_blk;
                        n_v.v3 = hr_v.v3 ^ r_blk;
                    end else if (r_fin) begin
                        n_v.v2  = hr_v.v2 ^ FIN_XOR;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (r_half != FIN_LAST) begin
                    n_v    = hr_v;
                    n_half = r_half + 3'd1;
                end else if (!r_out_valid || i_out_ready) begin
                    n_hash      = hr_v.v0 ^ hr_v.v1 ^ hr_v.v2 ^ hr_v.v3;
                    n_out_valid = 1'b1;
                    n_v         = key_load(r_key_lo, r_key_hi);
                    n_len       = '0;
                    n_fin       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  n_key_lo = i_cfg_wdata;
                CFG_KEY_HIGH: n_key_hi = i_cfg_wdata;
                default:      n_key_lo = r_key_lo;
            endcase
            n_v   = key_load(n_key_lo, n_key_hi);
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_lo    <= KEY_LOW_RESET;
            r_key_hi    <= KEY_HIGH_RESET;
            r_v         <= key_load(KEY_LOW_RESET, KEY_HIGH_RESET);
            r_len       <= '0;
            r_pend      <= 1'b0;
            r_fin       <= 1'b0;
            r_half      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key_lo    <= n_key_lo;
            r_key_hi    <= n_key_hi;
            r_v         <= n_v;
            r_len       <= n_len;
            r_pend      <= n_pend;
            r_fin       <= n_fin;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
        end
        r_m    <= n_m;
        r_blk  <= n_blk;
        r_hash <= n_hash;
    end

`ifndef NO_ASSERTIONS
    a_word_starts_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_COMP) && (r_half == 3'd0))
        else $error("request not followed by compression round");

    a_comp_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_half <= 3'd1))
        else $error("compression half-round count out of range");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN) && (r_state == S_IDLE))
        else $error("result raised outside finalisation");

    a_len_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_len == 8'd0) && !r_pend)
        else $error("length not cleared after result");
`endif

endmodule
`default_nettype wire

FILE: hdl/sh13_half_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SipHash half round
// Shared arithmetic unit: one half of a SipRound per use, two parallel 64-bit
// adds with their rotate and xor. Phase A is the first half, phase B the
// second.
// ----------------------------------------------------------------------------
module sh13_half_round
    import sh13_pkg::*;
(
    input  wire logic    i_phase,
    input  wire t_vstate i_v,
    output t_vstate      o_v
);

    logic [63:0] sum_a;
    logic [63:0] sum_b;

    always_comb begin
        o_v = i_v;
        unique case (i_phase)
            PHASE_A: begin
                sum_a  = i_v.v0 + i_v.v1;
                sum_b  = i_v.v2 + i_v.v3;
                o_v.v1 = rotl64(i_v.v1, 13) ^ sum_a;
                o_v.v0 = rotl64(sum_a, 32);
                o_v.v3 = rotl64(i_v.v3, 16) ^ sum_b;
                o_v.v2 = sum_b;
            end
            PHASE_B: begin
                sum_a  = i_v.v0 + i_v.v3;
                sum_b  = i_v.v2 + i_v.v1;
                o_v.v3 = rotl64(i_v.v3, 21) ^ sum_a;
                o_v.v0 = sum_a;
                o_v.v1 = rotl64(i_v.v1, 17) ^ sum_b;
                o_v.v2 = rotl64(sum_b, 32);
            end
            default: begin
                sum_a = '0;
                sum_b = '0;
            end
        endcase
    end

endmodule
`default_nettype wire
